>>> hw/rtl/pdr_pkg.sv
// Shared types and constants for the PWM divisor/range/duty calculator.
// No dependencies.
package pdr_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_APPLIED  = 2'd0;
    localparam logic [1:0] STATUS_OFF      = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_BASE_CLOCK_HZ     = 3'd0;
    localparam logic [2:0] CFG_DUTY_FULL_SCALE   = 3'd1;
    localparam logic [2:0] CFG_MIN_DIVISOR       = 3'd2;
    localparam logic [2:0] CFG_MAX_DIVISOR       = 3'd3;
    localparam logic [2:0] CFG_MAX_COUNTER_RANGE = 3'd4;

    localparam int unsigned FREQ_INT_W = 31;   // magnitude bits of a non-negative freq
    localparam int unsigned DUTY_W     = 16;

    // Request class flags carried down the pipeline
    typedef struct packed {
        logic neg;
        logic zero;
        logic is50;
    } req_flags_t;

endpackage

>>> hw/rtl/pdr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
module pdr_div_pipe #(
    parameter int NUM_W  = 40,
    parameter int DEN_W  = 47,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quot,
    output logic [DEN_W-1:0]  out_rem,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);

    // element 0 is the stage input, element k+1 the register of stage k
    logic              v_reg    [NUM_W+1];
    logic [DEN_W-1:0]  rem_reg  [NUM_W+1];
    logic [NUM_W-1:0]  num_reg  [NUM_W+1];
    logic [DEN_W-1:0]  den_reg  [NUM_W+1];
    logic [SIDE_W-1:0] side_reg [NUM_W+1];

    assign v_reg[0]    = in_valid;
    assign rem_reg[0]  = '0;
    assign num_reg[0]  = in_num;
    assign den_reg[0]  = in_den;
    assign side_reg[0] = in_side;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0] sh;
        logic           ge;
        logic [DEN_W:0] diff;

        assign sh   = {rem_reg[k], num_reg[k][NUM_W-1]};
        assign ge   = sh >= {1'b0, den_reg[k]};
        assign diff = sh - {1'b0, den_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
                num_reg[k+1]  <= {num_reg[k][NUM_W-2:0], ge};
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign out_quot  = num_reg[NUM_W];
    assign out_rem   = rem_reg[NUM_W];
    assign out_den   = den_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];

endmodule

>>> hw/rtl/pwm_divisor_range_duty_calc_unit.sv
// PWM clock divisor, counter range and compare value calculator, top level.
// Built around three bit-per-stage divider pipelines.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (aresetn, synchronous, active low) empties the pipeline and loads
//   the configuration registers with their default values.
module pwm_divisor_range_duty_calc_unit
    import pdr_pkg::*;
#(
    parameter int FREQ_FRAC_BITS = 8,
    parameter int DIVISOR_WIDTH  = 16,
    parameter int RANGE_WIDTH    = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wen,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_wdata,
    // request items
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [5:0]               s_channel,
    input  logic signed [31:0]       s_freq_q8,
    input  logic [15:0]              s_duty_width,
    // result items
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [5:0]               m_channel_out,
    output logic [1:0]               m_status,
    output logic [DIVISOR_WIDTH-1:0] m_clock_divisor,
    output logic [RANGE_WIDTH-1:0]   m_counter_range,
    output logic [31:0]              m_compare_value
);

    localparam int DW    = DIVISOR_WIDTH;
    localparam int RW    = RANGE_WIDTH;
    localparam int NUM_W = 32 + FREQ_FRAC_BITS;            // clock << frac bits
    localparam int FW    = FREQ_INT_W;
    localparam int P1_W  = FW + DUTY_W;                    // freq * full scale
    localparam int P2_W  = FW + DW;                        // freq * divisor
    localparam int RG_W  = (RW > DUTY_W) ? RW : DUTY_W;    // range before masking
    localparam int PR_W  = DUTY_W + RG_W;                  // duty * range

    typedef struct packed {
        logic [5:0]        chan;
        req_flags_t        flags;
        logic [FW-1:0]     f;
        logic [DUTY_W-1:0] w;
    } s1_t;

    typedef struct packed {
        logic [5:0]        chan;
        req_flags_t        flags;
        logic              recomp;
        logic [DW-1:0]     div;
        logic [FW-1:0]     f;
        logic [DUTY_W-1:0] w;
    } s2_t;

    typedef struct packed {
        logic [5:0]      chan;
        req_flags_t      flags;
        logic [DW-1:0]   div;
        logic [RG_W-1:0] range;
    } s3_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [31:0]     base_clk_reg;
    logic [15:0]     full_scale_reg;
    logic [DW-1:0]   min_div_reg;
    logic [DW-1:0]   max_div_reg;
    logic [RW-1:0]   max_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_clk_reg   <= 32'd19200000;
            full_scale_reg <= 16'd1024;
            min_div_reg    <= DW'(2);
            max_div_reg    <= DW'(4095);
            max_range_reg  <= RW'(65535);
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_BASE_CLOCK_HZ:     base_clk_reg   <= cfg_wdata;
                CFG_DUTY_FULL_SCALE:   full_scale_reg <= cfg_wdata[15:0];
                CFG_MIN_DIVISOR:       min_div_reg    <= cfg_wdata[DW-1:0];
                CFG_MAX_DIVISOR:       max_div_reg    <= cfg_wdata[DW-1:0];
                CFG_MAX_COUNTER_RANGE: max_range_reg  <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // zero-valued limits act as one
    logic [15:0]      dfs;
    logic [DW-1:0]    dmin;
    logic [DW-1:0]    dmax;
    logic [NUM_W-1:0] num;

    assign dfs  = (full_scale_reg == '0) ? 16'd1 : full_scale_reg;
    assign dmin = (min_div_reg == '0) ? DW'(1) : min_div_reg;
    assign dmax = (max_div_reg == '0) ? DW'(1) : max_div_reg;
    assign num  = NUM_W'(base_clk_reg) << FREQ_FRAC_BITS;

    // whole pipeline advances together; holds only while a result is refused
    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------------------------------------------------------
    // Stage A: classify request, saturate duty, freq * full scale
    // ---------------------------------------------------------------
    logic            a_valid_reg;
    s1_t             a_side_reg;
    logic [P1_W-1:0] a_p1_reg;
    s1_t             a_side_next;

    always_comb begin
        a_side_next.chan       = s_channel;
        a_side_next.flags.neg  = s_freq_q8[31];
        a_side_next.flags.zero = (s_freq_q8 == '0);
        a_side_next.flags.is50 = (s_freq_q8 == (32'sd50 <<< FREQ_FRAC_BITS));
        a_side_next.f          = s_freq_q8[FW-1:0];
        a_side_next.w          = (s_duty_width > dfs) ? dfs : s_duty_width;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= a_side_next;
            a_p1_reg   <= P1_W'(s_freq_q8[FW-1:0]) * P1_W'(dfs);
        end
    end

    // ---------------------------------------------------------------
    // Divider 1: clock / (freq * full scale)
    // ---------------------------------------------------------------
    logic             d1_valid;
    logic [NUM_W-1:0] d1_quot;
    logic [P1_W-1:0]  d1_rem;
    logic [P1_W-1:0]  d1_den;
    s1_t              d1_side;

    pdr_div_pipe #(.NUM_W(NUM_W), .DEN_W(P1_W), .SIDE_W($bits(s1_t))) u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_num    (num),
        .in_den    (a_p1_reg),
        .in_side   (a_side_reg),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_rem   (d1_rem),
        .out_den   (d1_den),
        .out_side  (d1_side)
    );

    // ---------------------------------------------------------------
    // Stage B: pick divisor and whether the range is recomputed
    // ---------------------------------------------------------------
    logic          b_valid_reg;
    s2_t           b_side_reg;
    s2_t           b_side_next;
    logic          rnd1;
    logic [NUM_W:0] div_rnd;
    logic [NUM_W:0] dmin_w;
    logic [NUM_W:0] dmax_w;
    logic [NUM_W:0] div_lo;
    logic [NUM_W:0] div_50;
    logic          too_low;
    logic          too_high;

    always_comb begin
        rnd1     = {d1_rem, 1'b0} >= {1'b0, d1_den};
        div_rnd  = {1'b0, d1_quot} + (NUM_W+1)'(rnd1);
        dmin_w   = (NUM_W+1)'(dmin);
        dmax_w   = (NUM_W+1)'(dmax);
        div_lo   = (div_rnd < dmin_w) ? dmin_w : div_rnd;
        div_50   = (div_lo > dmax_w) ? dmax_w : div_lo;
        too_low  = {1'b0, d1_quot} < dmin_w;
        too_high = ({1'b0, d1_quot} > dmax_w)
                   || (({1'b0, d1_quot} == dmax_w) && (d1_rem != '0));

        b_side_next.chan   = d1_side.chan;
        b_side_next.flags  = d1_side.flags;
        b_side_next.f      = d1_side.f;
        b_side_next.w      = d1_side.w;
        b_side_next.recomp = !d1_side.flags.is50 && (too_low || too_high);
        if (d1_side.flags.is50) begin
            b_side_next.div = div_50[DW-1:0];
        end else if (too_low) begin
            b_side_next.div = dmin;
        end else if (too_high) begin
            b_side_next.div = dmax;
        end else begin
            b_side_next.div = div_rnd[DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_side_reg <= b_side_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage C: freq * divisor
    // ---------------------------------------------------------------
    logic            c_valid_reg;
    s2_t             c_side_reg;
    logic [P2_W-1:0] c_p2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg <= b_side_reg;
            c_p2_reg   <= P2_W'(b_side_reg.f) * P2_W'(b_side_reg.div);
        end
    end

    // ---------------------------------------------------------------
    // Divider 2: clock / (freq * divisor), used when range is recomputed
    // ---------------------------------------------------------------
    logic             d2_valid;
    logic [NUM_W-1:0] d2_quot;
    logic [P2_W-1:0]  d2_rem;
    logic [P2_W-1:0]  d2_den;
    s2_t              d2_side;

    pdr_div_pipe #(.NUM_W(NUM_W), .DEN_W(P2_W), .SIDE_W($bits(s2_t))) u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_num    (num),
        .in_den    (c_p2_reg),
        .in_side   (c_side_reg),
        .out_valid (d2_valid),
        .out_quot  (d2_quot),
        .out_rem   (d2_rem),
        .out_den   (d2_den),
        .out_side  (d2_side)
    );

    // ---------------------------------------------------------------
    // Stage D: final range, full scale or recomputed and clamped to [2, max_counter_range]
    // ---------------------------------------------------------------
    logic           d_valid_reg;
    s3_t            d_side_reg;
    s3_t            d_side_next;
    logic           rnd2;
    logic [NUM_W:0] rng_rnd;
    logic [NUM_W:0] rng_lo;
    logic [NUM_W:0] rng_hi;
    logic [NUM_W:0] max_rng_w;

    // duty travels beside stage D
    logic [DUTY_W-1:0] d_w_reg;

    always_comb begin
        rnd2      = {d2_rem, 1'b0} >= {1'b0, d2_den};
        rng_rnd   = {1'b0, d2_quot} + (NUM_W+1)'(rnd2);
        max_rng_w = (NUM_W+1)'(max_range_reg);
        rng_lo    = (rng_rnd < (NUM_W+1)'(2)) ? (NUM_W+1)'(2) : rng_rnd;
        rng_hi    = (rng_lo > max_rng_w) ? max_rng_w : rng_lo;

        d_side_next.chan  = d2_side.chan;
        d_side_next.flags = d2_side.flags;
        d_side_next.div   = d2_side.div;
        d_side_next.range = d2_side.recomp ? RG_W'(rng_hi[RW-1:0]) : RG_W'(dfs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_side_reg <= d_side_next;
            d_w_reg    <= d2_side.w;
        end
    end

    // ---------------------------------------------------------------
    // Stage E: duty * range
    // ---------------------------------------------------------------
    logic            e_valid_reg;
    s3_t             e_side_reg;
    logic [PR_W-1:0] e_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_side_reg <= d_side_reg;
            e_prod_reg <= PR_W'(d_w_reg) * PR_W'(d_side_reg.range);
        end
    end

    // ---------------------------------------------------------------
    // Divider 3: (duty * range) / full scale
    // ---------------------------------------------------------------
    logic              d3_valid;
    logic [PR_W-1:0]   d3_quot;
    logic [DUTY_W-1:0] d3_rem;
    logic [DUTY_W-1:0] d3_den;
    s3_t               d3_side;

    pdr_div_pipe #(.NUM_W(PR_W), .DEN_W(DUTY_W), .SIDE_W($bits(s3_t))) u_div3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e_valid_reg),
        .in_num    (e_prod_reg),
        .in_den    (dfs),
        .in_side   (e_side_reg),
        .out_valid (d3_valid),
        .out_quot  (d3_quot),
        .out_rem   (d3_rem),
        .out_den   (d3_den),
        .out_side  (d3_side)
    );

    // ---------------------------------------------------------------
    // Stage F: round compare value, output register
    // ---------------------------------------------------------------
    logic            rnd3;
    logic [PR_W:0]   cmp_rnd;
    logic [RG_W-1:0] cmp_val;
    logic            applied;

    logic [5:0]      chan_reg;
    logic [1:0]      status_reg;
    logic [DW-1:0]   div_reg;
    logic [RW-1:0]   range_reg;
    logic [31:0]     cmp_reg;

    always_comb begin
        rnd3    = {d3_rem, 1'b0} >= {1'b0, d3_den};
        cmp_rnd = {1'b0, d3_quot} + (PR_W+1)'(rnd3);
        cmp_val = (cmp_rnd > (PR_W+1)'(d3_side.range)) ? d3_side.range
                                                       : cmp_rnd[RG_W-1:0];
        applied = !d3_side.flags.neg && !d3_side.flags.zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chan_reg <= d3_side.chan;
            if (d3_side.flags.neg) begin
                status_reg <= STATUS_REJECTED;
            end else if (d3_side.flags.zero) begin
                status_reg <= STATUS_OFF;
            end else begin
                status_reg <= STATUS_APPLIED;
            end
            div_reg   <= applied ? d3_side.div : '0;
            range_reg <= applied ? d3_side.range[RW-1:0] : '0;
            cmp_reg   <= applied ? 32'(cmp_val) : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_channel_out   = chan_reg;
    assign m_status        = status_reg;
    assign m_clock_divisor = div_reg;
    assign m_counter_range = range_reg;
    assign m_compare_value = cmp_reg;

endmodule

>>> bench/pdr_scoreboard.sv
// Checker for the PWM divisor/range/duty calculator: watches config writes and
// both item channels, predicts each result and compares it. Depends on pdr_pkg.
`timescale 1ns / 1ps

module pdr_scoreboard
    import pdr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wen,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [5:0]         s_channel,
    input  logic signed [31:0] s_freq_q8,
    input  logic [15:0]        s_duty_width,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [5:0]         m_channel_out,
    input  logic [1:0]         m_status,
    input  logic [15:0]        m_clock_divisor,
    input  logic [31:0]        m_counter_range,
    input  logic [31:0]        m_compare_value,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [5:0]  channel;
        logic [1:0]  status;
        logic [15:0] divisor;
        logic [31:0] range;
        logic [31:0] compare;
    } pwm_setting_t;

    pwm_setting_t settings_due[$];

    logic [31:0] clk_hz;
    logic [15:0] full_scale, div_lo, div_hi;
    logic [31:0] range_cap;

    function automatic logic [63:0] round_div(logic [63:0] n, logic [63:0] d);
        logic [63:0] q, r;
        q = n / d;
        r = n % d;
        if (r >= d - r) q++;
        return q;
    endfunction

    function automatic pwm_setting_t compute_setting(logic [5:0] ch, logic [31:0] fq,
                                                     logic [15:0] w_in);
        pwm_setting_t s;
        logic [63:0] f, d, dmin, dmax, num, w, dv, rg, q, r;
        s = '0;
        s.channel = ch;
        f    = {32'd0, fq};
        d    = (full_scale == 0) ? 64'd1 : {48'd0, full_scale};
        dmin = (div_lo == 0) ? 64'd1 : {48'd0, div_lo};
        dmax = (div_hi == 0) ? 64'd1 : {48'd0, div_hi};
        num  = {32'd0, clk_hz} << 8;
        w    = {48'd0, w_in};
        if (fq[31]) begin
            s.status = STATUS_REJECTED;
            return s;
        end
        if (fq == 0) begin
            s.status = STATUS_OFF;
            return s;
        end
        s.status = STATUS_APPLIED;
        if (f == (64'd50 << 8)) begin
            rg = d;
            dv = round_div(num, f * d);
            if (dv < dmin) dv = dmin;
            if (dv > dmax) dv = dmax;
        end else begin
            q = num / (f * d);
            r = num % (f * d);
            if (q < dmin || q > dmax || (q == dmax && r != 0)) begin
                dv = (q < dmin) ? dmin : dmax;
                rg = round_div(num, f * dv);
                if (rg < 2) rg = 2;
                if (rg > {32'd0, range_cap}) rg = {32'd0, range_cap};
            end else begin
                rg = d;
                dv = round_div(num, f * d);
            end
        end
        if (w > d) w = d;
        q = round_div(w * rg, d);
        if (q > rg) q = rg;
        s.divisor = dv[15:0];
        s.range   = rg[31:0];
        s.compare = q[31:0];
        return s;
    endfunction

    initial fail_count = 0;
    assign pending = settings_due.size();

    always @(posedge aclk) begin
        pwm_setting_t exp_s, got;
        if (!aresetn) begin
            clk_hz     = 32'd19200000;
            full_scale = 16'd1024;
            div_lo     = 16'd2;
            div_hi     = 16'd4095;
            range_cap  = 32'd65535;
            settings_due.delete();
        end else begin
            if (s_valid && s_ready)
                settings_due.insert(settings_due.size(),
                                    compute_setting(s_channel, s_freq_q8, s_duty_width));
            if (m_valid && m_ready) begin
                got = {m_channel_out, m_status, m_clock_divisor, m_counter_range,
                       m_compare_value};
                if (settings_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    exp_s = settings_due.pop_front();
                    if (got.channel != exp_s.channel) begin
                        fail_count++;
                        $display("%0t: channel exp %0d got %0d", $time, exp_s.channel,
                                 got.channel);
                    end
                    if (got.status != exp_s.status) begin
                        fail_count++;
                        $display("%0t: status exp %0d got %0d", $time, exp_s.status,
                                 got.status);
                    end
                    if (got.divisor != exp_s.divisor) begin
                        fail_count++;
                        $display("%0t: divisor exp %0d got %0d", $time, exp_s.divisor,
                                 got.divisor);
                    end
                    if (got.range != exp_s.range) begin
                        fail_count++;
                        $display("%0t: range exp %0d got %0d", $time, exp_s.range,
                                 got.range);
                    end
                    if (got.compare != exp_s.compare) begin
                        fail_count++;
                        $display("%0t: compare exp %0d got %0d", $time, exp_s.compare,
                                 got.compare);
                    end
                end
            end
            // config updates land after this edge's accepted item is predicted
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_BASE_CLOCK_HZ:     clk_hz     = cfg_wdata;
                    CFG_DUTY_FULL_SCALE:   full_scale = cfg_wdata[15:0];
                    CFG_MIN_DIVISOR:       div_lo     = cfg_wdata[15:0];
                    CFG_MAX_DIVISOR:       div_hi     = cfg_wdata[15:0];
                    CFG_MAX_COUNTER_RANGE: range_cap  = cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> bench/pwm_divisor_range_duty_calc_unit_tb.sv
// Top of the calculator testbench: clock, reset, config phases, request
// stimulus and result back-pressure. Depends on pdr_pkg, the DUT and pdr_scoreboard.
`timescale 1ns / 1ps

module pwm_divisor_range_duty_calc_unit_tb
    import pdr_pkg::*;
();

    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 600000;

    logic               aclk, aresetn;
    logic               cfg_wen;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               s_valid, s_ready;
    logic [5:0]         s_channel;
    logic signed [31:0] s_freq_q8;
    logic [15:0]        s_duty_width;
    logic               m_valid, m_ready;
    logic [5:0]         m_channel_out;
    logic [1:0]         m_status;
    logic [15:0]        m_clock_divisor;
    logic [31:0]        m_counter_range;
    logic [31:0]        m_compare_value;
    int                 fail_count, pending;
    int                 cycles;
    bit                 squeeze_req;   // asks the receiver for one long hold-off

    pwm_divisor_range_duty_calc_unit u_dut (.*);

    pdr_scoreboard u_scoreboard (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                m_ready = 1'b0;
                repeat (400) @(negedge aclk);
            end
            gap = pick_gap();
            if (gap == 0 || cycles % 2000 < 300) begin
                m_ready = 1'b1;     // stretches with no stalls
            end else begin
                m_ready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wen   = 1'b0;
    endtask

    task automatic load_regs(input logic [31:0] clk_hz, input logic [15:0] fs,
                             input logic [15:0] dmin, input logic [15:0] dmax,
                             input logic [31:0] rmax);
        // block must be drained first
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        write_reg(CFG_BASE_CLOCK_HZ, clk_hz);
        write_reg(CFG_DUTY_FULL_SCALE, {16'd0, fs});
        write_reg(CFG_MIN_DIVISOR, {16'd0, dmin});
        write_reg(CFG_MAX_DIVISOR, {16'd0, dmax});
        write_reg(CFG_MAX_COUNTER_RANGE, rmax);
    endtask

    // offer one request, held until accepted; called and returns at a falling edge
    task automatic send_request(input logic [5:0] ch, input logic [31:0] fq,
                                input logic [15:0] w, input bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        s_valid = 1'b0;
        repeat (gap) @(negedge aclk);
        s_valid      = 1'b1;
        s_channel    = ch;
        s_freq_q8    = fq;
        s_duty_width = w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // frequency mix: log-spread positives, exact 50 Hz, zero, negatives
    function automatic logic [31:0] pick_freq();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return 32'd50 << 8;
        if (roll < 13) return 32'd0;
        if (roll < 20) return $urandom | 32'h8000_0000;
        if (roll < 60) return $urandom_range(1, 32'h0004_0000);
        return ($urandom & 32'h7FFF_FFFF) >> $urandom_range(0, 30);
    endfunction

    function automatic logic [15:0] pick_duty();
        if ($urandom_range(0, 9) == 0) return 16'hFFFF;
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2048));
    endfunction

    task automatic random_burst(input int n);
        repeat (n)
            send_request(6'($urandom_range(0, 53)), pick_freq(), pick_duty(), 1'b1);
    endtask

    initial begin
        s_valid      = 1'b0;
        s_channel    = '0;
        s_freq_q8    = '0;
        s_duty_width = '0;
        cfg_wen      = 1'b0;
        cfg_index    = CFG_BASE_CLOCK_HZ;
        cfg_wdata    = '0;
        squeeze_req  = 1'b0;
        aresetn      = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: field extremes, off, reject, 50 Hz, clamp paths
        send_request(6'd0,  32'd0,         16'd0,     1'b0);
        send_request(6'd53, 32'h8000_0000, 16'hFFFF,  1'b0);
        send_request(6'd42, 32'hFFFF_FFFF, 16'd512,   1'b0);
        send_request(6'd21, 32'd50 << 8,   16'd512,   1'b0);
        send_request(6'd1,  32'd1,         16'hFFFF,  1'b0);
        send_request(6'd2,  32'h7FFF_FFFF, 16'd1024,  1'b0);
        send_request(6'd3,  32'd1000 << 8, 16'd1,     1'b0);
        send_request(6'd4,  32'd4688 << 8, 16'd1023,  1'b0);   // divisor near 4
        send_request(6'd5,  32'd2 << 8,    16'd300,   1'b0);   // divisor above max
        send_request(6'd6,  32'h0000_0080, 16'd700,   1'b0);   // half hertz
        send_request(6'd7,  (32'd50 << 8) + 1, 16'd100, 1'b0); // just off 50 Hz
        send_request(6'd8,  32'h5555_5555, 16'hAAAA,  1'b0);
        send_request(6'd9,  32'h2AAA_AAAA, 16'h5555,  1'b0);

        random_burst(150);
        squeeze_req = 1'b1;      // long receiver hold while requests keep coming
        random_burst(150);

        load_regs(32'd1, 16'd2, 16'd1, 16'd65535, 32'd2);
        send_request(6'd10, 32'd50 << 8, 16'd2, 1'b0);
        send_request(6'd11, 32'd1,       16'd1, 1'b0);
        random_burst(100);

        load_regs(32'hFFFF_FFFF, 16'd65535, 16'd1, 16'd65535, 32'hFFFF_FFFF);
        send_request(6'd12, 32'd50 << 8, 16'hFFFF, 1'b0);
        send_request(6'd13, 32'd1,       16'hFFFF, 1'b0);
        random_burst(120);

        // crossed divisor limits
        load_regs(32'd48000000, 16'd100, 16'd900, 16'd30, 32'd1000);
        send_request(6'd14, 32'd50 << 8, 16'd99, 1'b0);
        random_burst(100);

        load_regs(32'd125000000, 16'd4096, 16'd65535, 16'd65535, 32'd100000);
        random_burst(100);

        load_regs(32'd19200000, 16'd256, 16'd1, 16'd1, 32'd65535);
        random_burst(100);

        load_regs(32'd19200000, 16'd1024, 16'd2, 16'd4095, 32'd65535);
        random_burst(100);

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pdr_pkg.sv
hw/rtl/pdr_div_pipe.sv
hw/rtl/pwm_divisor_range_duty_calc_unit.sv
bench/pdr_scoreboard.sv
bench/pwm_divisor_range_duty_calc_unit_tb.sv
